// ===== src/arst_pkg.sv =====
package arst_pkg;

   localparam int WORD_WIDTH      = 32;
   localparam int FRAC_BITS       = 16;
   localparam int RADIUS_WIDTH    = WORD_WIDTH - 1;
   localparam int CSR_INDEX_WIDTH = 2;

   // radii after reset, in whole units
   localparam int STOP_RADIUS_UNITS = 5;
   localparam int SLOW_RADIUS_UNITS = 100;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_STOP_RADIUS = CSR_INDEX_WIDTH'(0);
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SLOW_RADIUS = CSR_INDEX_WIDTH'(1);

   typedef struct packed {
      logic signed [WORD_WIDTH-1:0] target_x;
      logic signed [WORD_WIDTH-1:0] target_y;
      logic signed [WORD_WIDTH-1:0] agent_x;
      logic signed [WORD_WIDTH-1:0] agent_y;
      logic signed [WORD_WIDTH-1:0] vel_x;
      logic signed [WORD_WIDTH-1:0] vel_y;
      logic [RADIUS_WIDTH-1:0]      max_speed;
   } req_type;

   typedef struct packed {
      logic signed [WORD_WIDTH-1:0] steer_x;
      logic signed [WORD_WIDTH-1:0] steer_y;
      logic                         stopped;
   } rsp_type;

endpackage

// ===== src/arst_sqrt_pipe.sv =====
module arst_sqrt_pipe
   import arst_pkg::*;
#(
   parameter int RW = 33,
   parameter int SW = 1
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              vld_i,
   input  logic [2*RW-1:0]   num_i,
   input  logic [SW-1:0]     side_i,
   output logic              vld_o,
   output logic [RW-1:0]     root_o,
   output logic [SW-1:0]     side_o
);

   // one root bit per stage, remainder kept as num - root^2
   logic              vld_ff  [0:RW-1];
   logic [2*RW-1:0]   rem_ff  [0:RW-1];
   logic [RW-1:0]     root_ff [0:RW-1];
   logic [SW-1:0]     side_ff [0:RW-1];

   for (genvar k = 0; k < RW; k++) begin : g_step
      logic              vld_src;
      logic [2*RW-1:0]   rem_src;
      logic [RW-1:0]     root_src;
      logic [SW-1:0]     side_src;
      logic [2*RW-1:0]   trial;
      logic              take;
      logic [2*RW-1:0]   rem_in;
      logic [RW-1:0]     root_in;

      if (k == 0) begin : g_first
         assign vld_src  = vld_i;
         assign rem_src  = num_i;
         assign root_src = '0;
         assign side_src = side_i;
      end else begin : g_next
         assign vld_src  = vld_ff[k-1];
         assign rem_src  = rem_ff[k-1];
         assign root_src = root_ff[k-1];
         assign side_src = side_ff[k-1];
      end

      // (r + 2^j)^2 - r^2 = r*2^(j+1) + 2^(2j)
      assign trial = ((2*RW)'(root_src) << (RW - k)) | ((2*RW)'(1) << (2*(RW - 1 - k)));
      assign take  = rem_src >= trial;

      always_comb begin
         rem_in  = take ? rem_src - trial : rem_src;
         root_in = take ? root_src | (RW'(1) << (RW - 1 - k)) : root_src;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else begin
            vld_ff[k] <= vld_src;
         end
         rem_ff[k]  <= rem_in;
         root_ff[k] <= root_in;
         side_ff[k] <= side_src;
      end
   end

   assign vld_o  = vld_ff[RW-1];
   assign root_o = root_ff[RW-1];
   assign side_o = side_ff[RW-1];

endmodule

// ===== src/arst_div_pipe.sv =====
module arst_div_pipe
   import arst_pkg::*;
#(
   parameter int DW = 31,
   parameter int QW = 31,
   parameter int SW = 1
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                vld_i,
   input  logic [DW+QW-1:0]    num_i,
   input  logic [DW-1:0]       den_i,
   input  logic [SW-1:0]       side_i,
   output logic                vld_o,
   output logic [QW-1:0]       quo_o,
   output logic [SW-1:0]       side_o
);

   // restoring division, one quotient bit per stage; num < den * 2^QW
   localparam int CW = DW + QW;

   logic            vld_ff  [0:QW-1];
   logic [CW-1:0]   rem_ff  [0:QW-1];
   logic [DW-1:0]   den_ff  [0:QW-1];
   logic [QW-1:0]   quo_ff  [0:QW-1];
   logic [SW-1:0]   side_ff [0:QW-1];

   for (genvar k = 0; k < QW; k++) begin : g_step
      logic            vld_src;
      logic [CW-1:0]   rem_src;
      logic [DW-1:0]   den_src;
      logic [QW-1:0]   quo_src;
      logic [SW-1:0]   side_src;
      logic [CW-1:0]   shifted;
      logic            take;
      logic [CW-1:0]   rem_in;
      logic [QW-1:0]   quo_in;

      if (k == 0) begin : g_first
         assign vld_src  = vld_i;
         assign rem_src  = num_i;
         assign den_src  = den_i;
         assign quo_src  = '0;
         assign side_src = side_i;
      end else begin : g_next
         assign vld_src  = vld_ff[k-1];
         assign rem_src  = rem_ff[k-1];
         assign den_src  = den_ff[k-1];
         assign quo_src  = quo_ff[k-1];
         assign side_src = side_ff[k-1];
      end

      assign shifted = CW'(den_src) << (QW - 1 - k);
      assign take    = rem_src >= shifted;

      always_comb begin
         rem_in = take ? rem_src - shifted : rem_src;
         quo_in = take ? quo_src | (QW'(1) << (QW - 1 - k)) : quo_src;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else begin
            vld_ff[k] <= vld_src;
         end
         rem_ff[k]  <= rem_in;
         den_ff[k]  <= den_src;
         quo_ff[k]  <= quo_in;
         side_ff[k] <= side_src;
      end
   end

   assign vld_o  = vld_ff[QW-1];
   assign quo_o  = quo_ff[QW-1];
   assign side_o = side_ff[QW-1];

endmodule

// ===== src/arrive_steering_core.sv =====
// Arrive steering unit, signed fixed point with FRAC_BITS fraction bits.
// Request channel: req_data is taken on a clock edge where start is high and
// busy is low. busy never rises, so one request can be taken every cycle.
// Response channel: rsp_valid is high for one cycle with rsp_data; there is
// no back-pressure, the receiver takes every response in its cycle.
// Responses leave in request order, one per request.
// The pipeline holds two integer square roots of WORD_WIDTH+1 stages each
// and three levels of restoring dividers of WORD_WIDTH-1 stages each, one
// result bit per stage, plus ten stages for differences, squares, products
// and the final select and saturate.
// Throughput is one request per cycle.
// CSR channel: csr_index selects stop_radius (0) or slow_radius (1);
// csr_ready is always high, other indices are dropped. Write the radii only
// while no request is in flight.
// Synchronous reset empties the pipeline and restores the radii to 5.0 and
// 100.0.
module arrive_steering_core
   import arst_pkg::*;
#(
   parameter int FRAC = FRAC_BITS
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  req_type                      req_data,
   output logic                         rsp_valid,
   output rsp_type                      rsp_data,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [CSR_INDEX_WIDTH-1:0]   csr_index,
   input  logic [RADIUS_WIDTH-1:0]      csr_data
);

   localparam int W   = WORD_WIDTH;
   localparam int R   = RADIUS_WIDTH;
   localparam int DW  = W + 1;
   localparam int SQW = 2 * DW;

   localparam logic [R-1:0] STOP_RESET = R'(64'(STOP_RADIUS_UNITS) << FRAC);
   localparam logic [R-1:0] SLOW_RESET = R'(64'(SLOW_RADIUS_UNITS) << FRAC);

   typedef struct packed {
      logic signed [DW-1:0] dx;
      logic signed [DW-1:0] dy;
      logic signed [W-1:0]  vx;
      logic signed [W-1:0]  vy;
      logic [R-1:0]         ms;
   } base_type;

   typedef struct packed {
      base_type             base;
      logic [DW-1:0]        dlen;
      logic                 stopped;
      logic                 slowing;
   } speed_side_type;

   typedef struct packed {
      logic                 stopped;
      logic                 dzero;
      logic                 neg_x;
      logic signed [W-1:0]  vx;
      logic signed [W-1:0]  vy;
      logic [R-1:0]         ms;
   } want_side_type;

   typedef struct packed {
      logic signed [DW-1:0] sx;
      logic signed [DW-1:0] sy;
      logic                 stopped;
      logic signed [W-1:0]  vx;
      logic signed [W-1:0]  vy;
      logic [R-1:0]         ms;
   } steer_side_type;

   typedef struct packed {
      logic signed [DW-1:0] sx;
      logic signed [DW-1:0] sy;
      logic                 stopped;
      logic                 clamp;
      logic signed [W-1:0]  vx;
      logic signed [W-1:0]  vy;
   } clamp_side_type;

   function automatic logic [DW-1:0] mag_dw(input logic signed [DW-1:0] v);
      return v[DW-1] ? (~v + 1'b1) : v;
   endfunction

   function automatic logic [W-1:0] sat_w(input logic signed [DW-1:0] v);
      logic [W-1:0] res;
      if (v[DW-1] != v[DW-2]) begin
         res = v[DW-1] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
      end else begin
         res = v[W-1:0];
      end
      return res;
   endfunction

   // ---------------- configuration
   logic [R-1:0] stop_ff, stop_in;
   logic [R-1:0] slow_ff, slow_in;

   assign csr_ready = 1'b1;
   assign busy      = 1'b0;

   always_comb begin
      stop_in = stop_ff;
      slow_in = slow_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_STOP_RADIUS: stop_in = csr_data;
            CSR_SLOW_RADIUS: slow_in = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stop_ff <= STOP_RESET;
         slow_ff <= SLOW_RESET;
      end else begin
         stop_ff <= stop_in;
         slow_ff <= slow_in;
      end
   end

   // ---------------- offsets
   logic     in_vld_ff;
   base_type in_base_ff, in_base_in;

   always_comb begin
      in_base_in.dx = {req_data.target_x[W-1], req_data.target_x}
                    - {req_data.agent_x[W-1], req_data.agent_x};
      in_base_in.dy = {req_data.target_y[W-1], req_data.target_y}
                    - {req_data.agent_y[W-1], req_data.agent_y};
      in_base_in.vx = req_data.vel_x;
      in_base_in.vy = req_data.vel_y;
      in_base_in.ms = req_data.max_speed;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else begin
         in_vld_ff <= start && !busy;
      end
      in_base_ff <= in_base_in;
   end

   // ---------------- squares of the offset
   logic           sq_vld_ff;
   logic [SQW-1:0] sq_x_ff, sq_y_ff;
   base_type       sq_base_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_vld_ff <= 1'b0;
      end else begin
         sq_vld_ff <= in_vld_ff;
      end
      sq_x_ff    <= SQW'(mag_dw(in_base_ff.dx)) * SQW'(mag_dw(in_base_ff.dx));
      sq_y_ff    <= SQW'(mag_dw(in_base_ff.dy)) * SQW'(mag_dw(in_base_ff.dy));
      sq_base_ff <= in_base_ff;
   end

   logic           sum_vld_ff;
   logic [SQW-1:0] sum_ff;
   base_type       sum_base_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_vld_ff <= 1'b0;
      end else begin
         sum_vld_ff <= sq_vld_ff;
      end
      sum_ff      <= sq_x_ff + sq_y_ff;
      sum_base_ff <= sq_base_ff;
   end

   // ---------------- distance
   logic          da_vld;
   logic [DW-1:0] da_root;
   base_type      da_side;

   arst_sqrt_pipe #(
      .RW (DW),
      .SW ($bits(base_type))
   ) u_dist_sqrt (
      .clock  (clock),
      .reset  (reset),
      .vld_i  (sum_vld_ff),
      .num_i  (sum_ff),
      .side_i (sum_base_ff),
      .vld_o  (da_vld),
      .root_o (da_root),
      .side_o (da_side)
   );

   // ---------------- radius checks and slowed-speed product
   logic           dist_vld_ff;
   logic [2*R-1:0] dist_prod_ff;
   speed_side_type dist_side_ff, dist_side_in;
   logic [2*W-1:0] dist_full;

   assign dist_full = (2*W)'(da_side.ms) * (2*W)'(da_root);

   always_comb begin
      dist_side_in.base    = da_side;
      dist_side_in.dlen    = da_root;
      dist_side_in.stopped = da_root < DW'(stop_ff);
      dist_side_in.slowing = da_root < DW'(slow_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dist_vld_ff <= 1'b0;
      end else begin
         dist_vld_ff <= da_vld;
      end
      dist_prod_ff <= dist_full[2*R-1:0];
      dist_side_ff <= dist_side_in;
   end

   logic           sd_vld;
   logic [R-1:0]   sd_quo;
   speed_side_type sd_side;

   arst_div_pipe #(
      .DW (R),
      .QW (R),
      .SW ($bits(speed_side_type))
   ) u_speed_div (
      .clock  (clock),
      .reset  (reset),
      .vld_i  (dist_vld_ff),
      .num_i  (dist_prod_ff),
      .den_i  (slow_ff),
      .side_i (dist_side_ff),
      .vld_o  (sd_vld),
      .quo_o  (sd_quo),
      .side_o (sd_side)
   );

   // ---------------- desired velocity products
   logic           spd_vld_ff;
   logic [2*W-1:0] spd_px_ff, spd_py_ff;
   logic [DW-1:0]  spd_dist_ff;
   logic           spd_neg_y_ff;
   want_side_type  spd_side_ff, spd_side_in;
   logic [R-1:0]   speed;

   assign speed = sd_side.slowing ? sd_quo : sd_side.base.ms;

   always_comb begin
      spd_side_in.stopped = sd_side.stopped;
      spd_side_in.dzero   = sd_side.dlen == '0;
      spd_side_in.neg_x   = sd_side.base.dx[DW-1];
      spd_side_in.vx      = sd_side.base.vx;
      spd_side_in.vy      = sd_side.base.vy;
      spd_side_in.ms      = sd_side.base.ms;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         spd_vld_ff <= 1'b0;
      end else begin
         spd_vld_ff <= sd_vld;
      end
      spd_px_ff    <= (2*W)'(mag_dw(sd_side.base.dx)) * (2*W)'(speed);
      spd_py_ff    <= (2*W)'(mag_dw(sd_side.base.dy)) * (2*W)'(speed);
      spd_dist_ff  <= sd_side.dlen;
      spd_neg_y_ff <= sd_side.base.dy[DW-1];
      spd_side_ff  <= spd_side_in;
   end

   logic          wx_vld;
   logic [R-1:0]  wx_quo, wy_quo;
   want_side_type wx_side;
   logic          wy_neg;

   arst_div_pipe #(
      .DW (DW),
      .QW (R),
      .SW ($bits(want_side_type))
   ) u_want_x_div (
      .clock  (clock),
      .reset  (reset),
      .vld_i  (spd_vld_ff),
      .num_i  (spd_px_ff),
      .den_i  (spd_dist_ff),
      .side_i (spd_side_ff),
      .vld_o  (wx_vld),
      .quo_o  (wx_quo),
      .side_o (wx_side)
   );

   arst_div_pipe #(
      .DW (DW),
      .QW (R),
      .SW (1)
   ) u_want_y_div (
      .clock  (clock),
      .reset  (reset),
      .vld_i  (spd_vld_ff),
      .num_i  (spd_py_ff),
      .den_i  (spd_dist_ff),
      .side_i (spd_neg_y_ff),
      .vld_o  (),
      .quo_o  (wy_quo),
      .side_o (wy_neg)
   );

   // ---------------- raw steering = desired - velocity
   logic                 str_vld_ff;
   steer_side_type       str_side_ff, str_side_in;
   logic signed [DW-1:0] want_x, want_y;

   always_comb begin
      want_x = wx_side.neg_x ? -$signed(DW'(wx_quo)) : $signed(DW'(wx_quo));
      want_y = wy_neg        ? -$signed(DW'(wy_quo)) : $signed(DW'(wy_quo));
      if (wx_side.dzero) begin
         want_x = '0;
         want_y = '0;
      end
      str_side_in.sx      = want_x - {wx_side.vx[W-1], wx_side.vx};
      str_side_in.sy      = want_y - {wx_side.vy[W-1], wx_side.vy};
      str_side_in.stopped = wx_side.stopped;
      str_side_in.vx      = wx_side.vx;
      str_side_in.vy      = wx_side.vy;
      str_side_in.ms      = wx_side.ms;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         str_vld_ff <= 1'b0;
      end else begin
         str_vld_ff <= wx_vld;
      end
      str_side_ff <= str_side_in;
   end

   logic           ssq_vld_ff;
   logic [SQW-1:0] ssq_x_ff, ssq_y_ff;
   steer_side_type ssq_side_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ssq_vld_ff <= 1'b0;
      end else begin
         ssq_vld_ff <= str_vld_ff;
      end
      ssq_x_ff    <= SQW'(mag_dw(str_side_ff.sx)) * SQW'(mag_dw(str_side_ff.sx));
      ssq_y_ff    <= SQW'(mag_dw(str_side_ff.sy)) * SQW'(mag_dw(str_side_ff.sy));
      ssq_side_ff <= str_side_ff;
   end

   logic           ssum_vld_ff;
   logic [SQW-1:0] ssum_ff;
   steer_side_type ssum_side_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ssum_vld_ff <= 1'b0;
      end else begin
         ssum_vld_ff <= ssq_vld_ff;
      end
      ssum_ff      <= ssq_x_ff + ssq_y_ff;
      ssum_side_ff <= ssq_side_ff;
   end

   logic           ln_vld;
   logic [DW-1:0]  ln_root;
   steer_side_type ln_side;

   arst_sqrt_pipe #(
      .RW (DW),
      .SW ($bits(steer_side_type))
   ) u_steer_sqrt (
      .clock  (clock),
      .reset  (reset),
      .vld_i  (ssum_vld_ff),
      .num_i  (ssum_ff),
      .side_i (ssum_side_ff),
      .vld_o  (ln_vld),
      .root_o (ln_root),
      .side_o (ln_side)
   );

   // ---------------- length clamp products
   logic           clp_vld_ff;
   logic [2*W-1:0] clp_px_ff, clp_py_ff;
   logic [DW-1:0]  clp_len_ff;
   logic           clp_neg_y_ff;
   clamp_side_type clp_side_ff, clp_side_in;

   always_comb begin
      clp_side_in.sx      = ln_side.sx;
      clp_side_in.sy      = ln_side.sy;
      clp_side_in.stopped = ln_side.stopped;
      clp_side_in.clamp   = ln_root > DW'(ln_side.ms);
      clp_side_in.vx      = ln_side.vx;
      clp_side_in.vy      = ln_side.vy;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clp_vld_ff <= 1'b0;
      end else begin
         clp_vld_ff <= ln_vld;
      end
      clp_px_ff    <= (2*W)'(mag_dw(ln_side.sx)) * (2*W)'(ln_side.ms);
      clp_py_ff    <= (2*W)'(mag_dw(ln_side.sy)) * (2*W)'(ln_side.ms);
      clp_len_ff   <= ln_root;
      clp_neg_y_ff <= ln_side.sy[DW-1];
      clp_side_ff  <= clp_side_in;
   end

   logic           cx_vld;
   logic [R-1:0]   cx_quo, cy_quo;
   clamp_side_type cx_side;
   logic           cy_neg;

   arst_div_pipe #(
      .DW (DW),
      .QW (R),
      .SW ($bits(clamp_side_type))
   ) u_clamp_x_div (
      .clock  (clock),
      .reset  (reset),
      .vld_i  (clp_vld_ff),
      .num_i  (clp_px_ff),
      .den_i  (clp_len_ff),
      .side_i (clp_side_ff),
      .vld_o  (cx_vld),
      .quo_o  (cx_quo),
      .side_o (cx_side)
   );

   arst_div_pipe #(
      .DW (DW),
      .QW (R),
      .SW (1)
   ) u_clamp_y_div (
      .clock  (clock),
      .reset  (reset),
      .vld_i  (clp_vld_ff),
      .num_i  (clp_py_ff),
      .den_i  (clp_len_ff),
      .side_i (clp_neg_y_ff),
      .vld_o  (),
      .quo_o  (cy_quo),
      .side_o (cy_neg)
   );

   // ---------------- select and saturate
   logic                 rsp_valid_ff;
   rsp_type              rsp_data_ff, rsp_data_in;
   logic signed [DW-1:0] fin_x, fin_y;

   always_comb begin
      if (cx_side.stopped) begin
         fin_x = -$signed({cx_side.vx[W-1], cx_side.vx});
         fin_y = -$signed({cx_side.vy[W-1], cx_side.vy});
      end else if (cx_side.clamp) begin
         fin_x = cx_side.sx[DW-1] ? -$signed(DW'(cx_quo)) : $signed(DW'(cx_quo));
         fin_y = cy_neg           ? -$signed(DW'(cy_quo)) : $signed(DW'(cy_quo));
      end else begin
         fin_x = cx_side.sx;
         fin_y = cx_side.sy;
      end
      rsp_data_in.steer_x = sat_w(fin_x);
      rsp_data_in.steer_y = sat_w(fin_y);
      rsp_data_in.stopped = cx_side.stopped;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cx_vld;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
